// File: hw/rtl/jsu_pkg.sv
// Shared types and codes for the JSON string unescape block.
package jsu_pkg;

   // Result kinds
   localparam logic [2:0] KIND_DATA = 3'd0;
   localparam logic [2:0] KIND_END  = 3'd1;
   localparam logic [2:0] KIND_ESC  = 3'd2;
   localparam logic [2:0] KIND_HEX  = 3'd3;
   localparam logic [2:0] KIND_SURR = 3'd4;
   localparam logic [2:0] KIND_NUL  = 3'd5;

   // Input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_string;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] kind;
      logic       last;
   } rsp_type;

   // One decoded event from the front: a raw byte, a code point or a status
   typedef struct packed {
      logic [2:0]  kind;
      logic        raw;
      logic [20:0] cp;
   } job_type;

endpackage

// File: hw/rtl/jsu_front.sv
// Front end: accepts body bytes, tracks escape state, queues decoded events.
module jsu_front
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output job_type push_job,
   input  logic    full
);

   typedef enum logic [6:0] {
      PH_HALT   = 7'b0000001,
      PH_BODY   = 7'b0000010,
      PH_ESC    = 7'b0000100,
      PH_HEX1   = 7'b0001000,
      PH_WANTBS = 7'b0010000,
      PH_WANTU  = 7'b0100000,
      PH_HEX2   = 7'b1000000
   } phase_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [15:0] hex_ff, hex_in, hex_next;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  high_ff, high_in;
   logic        accept;
   logic [7:0]  c;
   logic        dig_ok;
   logic [3:0]  dig;

   // Decode one hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = '0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         r = {1'b1, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         r = {1'b1, 4'(ch - 8'h57)};
      end
      return r;
   endfunction

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign c         = req_data.in_byte;
   assign {dig_ok, dig} = hex_digit(c);
   assign hex_next  = {hex_ff[11:0], dig};
   assign phase_cur = req_data.new_string ? PH_BODY : phase_ff;

   // Advance the decoder on each accepted beat
   always_comb begin
      phase_in = phase_ff;
      hex_in   = hex_ff;
      cnt_in   = cnt_ff;
      high_in  = high_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         phase_in = phase_cur;
         if (req_data.new_string) begin
            hex_in  = '0;
            cnt_in  = '0;
            high_in = '0;
         end
         case (phase_cur)
            PH_BODY: begin
               if (c == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else if (c == CH_QUOTE) begin
                  push = 1'b1; push_job.kind = KIND_END; phase_in = PH_HALT;
               end else if (c == 8'h00) begin
                  push = 1'b1; push_job.kind = KIND_NUL; phase_in = PH_HALT;
               end else if (c < 8'h20) begin
                  push = 1'b1; push_job.kind = KIND_ESC; phase_in = PH_HALT;
               end else begin
                  push = 1'b1; push_job.raw = 1'b1; push_job.cp = {13'd0, c};
               end
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               push     = 1'b1;
               case (c)
                  CH_QUOTE, CH_SLASH, CH_BSLASH: push_job.cp = {13'd0, c};
                  8'h62: push_job.cp = 21'h08;
                  8'h66: push_job.cp = 21'h0C;
                  8'h6E: push_job.cp = 21'h0A;
                  8'h72: push_job.cp = 21'h0D;
                  8'h74: push_job.cp = 21'h09;
                  CH_U: begin
                     push     = 1'b0;
                     phase_in = PH_HEX1;
                     hex_in   = '0;
                     cnt_in   = '0;
                  end
                  default: begin
                     push_job.kind = KIND_ESC;
                     phase_in      = PH_HALT;
                  end
               endcase
            end
            PH_WANTBS: begin
               if (c != CH_BSLASH) begin
                  push = 1'b1; push_job.kind = KIND_SURR; phase_in = PH_HALT;
               end else begin
                  phase_in = PH_WANTU;
               end
            end
            PH_WANTU: begin
               if (c != CH_U) begin
                  push = 1'b1; push_job.kind = KIND_SURR; phase_in = PH_HALT;
               end else begin
                  phase_in = PH_HEX2;
                  hex_in   = '0;
                  cnt_in   = '0;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (!dig_ok) begin
                  push = 1'b1; push_job.kind = KIND_HEX; phase_in = PH_HALT;
               end else begin
                  hex_in = hex_next;
                  if (cnt_ff != 2'd3) begin
                     cnt_in = cnt_ff + 2'd1;
                  end else begin
                     cnt_in = '0;
                     if (phase_cur == PH_HEX1) begin
                        // hold a high surrogate and wait for its partner
                        if (hex_next[15:10] == 6'b110110) begin
                           high_in  = hex_next[9:0];
                           phase_in = PH_WANTBS;
                        end else begin
                           push        = 1'b1;
                           push_job.cp = {5'd0, hex_next};
                           phase_in    = PH_BODY;
                        end
                     end else if (hex_next[15:10] != 6'b110111) begin
                        push = 1'b1; push_job.kind = KIND_SURR; phase_in = PH_HALT;
                     end else begin
                        push        = 1'b1;
                        push_job.cp = {1'b0, high_ff, hex_next[9:0]} + 21'h10000;
                        phase_in    = PH_BODY;
                     end
                  end
               end
            end
            default: phase_in = PH_HALT;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HALT;
         hex_ff   <= '0;
         cnt_ff   <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         cnt_ff   <= cnt_in;
         high_ff  <= high_in;
      end
   end

endmodule

// File: hw/rtl/jsu_queue.sv
// Event queue between the front end and the output expander.
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy exceeds depth");

   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push lost from queue");

endmodule

// File: hw/rtl/jsu_back.sv
// Back end: expands queued events into UTF-8 result beats.
module jsu_back
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic [1:0] last_idx;
   logic       load;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // Number of bytes an event expands to, minus one
   function automatic logic [1:0] byte_span(input job_type j);
      logic [1:0] r;
      if (j.raw || j.kind != KIND_DATA || j.cp <= 21'h7F) begin
         r = 2'd0;
      end else if (j.cp <= 21'h7FF) begin
         r = 2'd1;
      end else if (j.cp <= 21'hFFFF) begin
         r = 2'd2;
      end else begin
         r = 2'd3;
      end
      return r;
   endfunction

   // Byte at a given position of the encoded sequence
   function automatic logic [7:0] utf8_byte(input job_type j, input logic [1:0] span,
                                            input logic [1:0] pos);
      logic [7:0] r;
      r = 8'h00;
      if (j.kind == KIND_DATA) begin
         case (span)
            2'd0: r = j.cp[7:0];
            2'd1: r = (pos == 2'd0) ? {3'b110, j.cp[10:6]} : {2'b10, j.cp[5:0]};
            2'd2: begin
               case (pos)
                  2'd0:    r = {4'b1110, j.cp[15:12]};
                  2'd1:    r = {2'b10, j.cp[11:6]};
                  default: r = {2'b10, j.cp[5:0]};
               endcase
            end
            default: begin
               case (pos)
                  2'd0:    r = {5'b11110, j.cp[20:18]};
                  2'd1:    r = {2'b10, j.cp[17:12]};
                  2'd2:    r = {2'b10, j.cp[11:6]};
                  default: r = {2'b10, j.cp[5:0]};
               endcase
            end
         endcase
      end
      return r;
   endfunction

   assign last_idx = byte_span(head_job);
   assign load     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop      = load && (idx_ff == last_idx);

   // Load the output register and step through the bytes of the event
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = utf8_byte(head_job, last_idx, idx_ff);
         rsp_data_in.kind     = head_job.kind;
         rsp_data_in.last     = (idx_ff == last_idx);
         idx_in               = (idx_ff == last_idx) ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_status_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind != KIND_DATA) |-> rsp_data_ff.last)
      else $error("status beat not marked last");

   a_status_zero_byte : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind != KIND_DATA) |-> (rsp_data_ff.out_byte == 8'h00))
      else $error("status beat carries a byte");

   a_idx_in_span : assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= last_idx))
      else $error("byte index beyond event length");

   a_idle_idx : assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == 2'd0))
      else $error("byte index left set with empty queue");

endmodule

// File: hw/rtl/json_string_unescape_utf8.sv
// Top level of the JSON string body decoder with UTF-8 output.
//
//   channel   dir   handshake               payload
//   req       in    req_valid / req_stall   req_data  (in_byte, new_string)
//   rsp       out   rsp_valid / rsp_stall   rsp_data  (out_byte, kind, last)
//
// One input beat is taken per cycle while the event queue has room.
// Each event drains at one result beat per cycle from the output register while rsp is not stalled;
// a \uXXXX escape gives 1 to 3 beats and a surrogate pair gives 4, so its expansion sets the drain time.
// Synchronous reset clears the decoder state, queue pointers and output valid.
// A stall on rsp fills the queue (QUEUE_DEPTH events) before req_stall rises.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .full      (full)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
